// File: src/vst_pkg.sv
// ----------------------------------------------------------------------------
// vst_pkg: shared types and constants for the variable symbol table
// Holds the table geometry, the status codes, the item record that travels
// along the cell chain, the insert command, and the name normalizing function.
// ----------------------------------------------------------------------------
package vst_pkg;

  localparam int TABLE_DEPTH    = 64;
  localparam int NAME_CHARS     = 20;
  localparam int CHARS_PER_WORD = 10;
  localparam int CODE_BITS      = 6;
  localparam int WORD_W         = CHARS_PER_WORD * CODE_BITS;
  localparam int VALUE_W        = 64;
  localparam int IDX_W          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W          = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } state_t;

  // Record handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic               active;
    logic               is_assign;
    logic [WORD_W-1:0]  key_high;
    logic [WORD_W-1:0]  key_low;
    logic [VALUE_W-1:0] data;
    logic               hit;
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
  } tok_t;

  // Insert command broadcast to the row after an assign scan finds no match and a free cell.
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [WORD_W-1:0]  key_high;
    logic [WORD_W-1:0]  key_low;
    logic [VALUE_W-1:0] data;
  } ins_t;

  // A name ends at its first padding code; everything after it, and every
  // character beyond NAME_CHARS, is forced to padding.
  function automatic logic [2*WORD_W-1:0] normalize(input logic [WORD_W-1:0] hi,
                                                    input logic [WORD_W-1:0] lo);
    logic [2*WORD_W-1:0] name;
    logic                ended;
    logic [CODE_BITS-1:0] code;
    int                  pos;
    name  = {hi, lo};
    ended = 1'b0;
    for (int c = 0; c < 2 * CHARS_PER_WORD; c++) begin
      pos  = (2 * CHARS_PER_WORD - 1 - c) * CODE_BITS;
      code = name[pos +: CODE_BITS];
      if (c >= NAME_CHARS || code == '0) ended = 1'b1;
      if (ended) name[pos +: CODE_BITS] = '0;
    end
    return name;
  endfunction

endpackage

// File: src/vst_cell.sv
// ----------------------------------------------------------------------------
// vst_cell: one table entry of the symbol table chain
// Holds a key and a value, compares the passing item against its key, serves
// or updates the value on the first match, and reports itself when free.
// ----------------------------------------------------------------------------
module vst_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [vst_pkg::IDX_W-1:0] cell_idx,
  input  vst_pkg::tok_t            tok_in,
  input  vst_pkg::ins_t            ins,
  output vst_pkg::tok_t            tok_out
);
  import vst_pkg::*;

  logic [WORD_W-1:0]  key_high;
  logic [WORD_W-1:0]  key_low;
  logic [VALUE_W-1:0] value;
  logic               valid;
  logic               match;
  logic               take_free;
  logic               ins_here;
  tok_t               tok_next;

  assign match     = tok_in.active && valid && !tok_in.hit &&
                     key_high == tok_in.key_high && key_low == tok_in.key_low;
  assign take_free = tok_in.active && !valid && !tok_in.free_found;
  assign ins_here  = ins.en && ins.idx == cell_idx;

  always_comb begin
    tok_next = tok_in;
    if (match) begin
      tok_next.hit = 1'b1;
      if (!tok_in.is_assign) tok_next.data = value;
    end
    if (take_free) begin
      tok_next.free_found = 1'b1;
      tok_next.free_idx   = cell_idx;
    end
  end

  // Only the valid bit and the item marker need a reset; the rest is data.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid          <= 1'b0;
      tok_out.active <= 1'b0;
    end else begin
      if (ins_here) valid <= 1'b1;
      tok_out.active <= tok_next.active;
    end
    tok_out.is_assign  <= tok_next.is_assign;
    tok_out.key_high   <= tok_next.key_high;
    tok_out.key_low    <= tok_next.key_low;
    tok_out.data       <= tok_next.data;
    tok_out.hit        <= tok_next.hit;
    tok_out.free_found <= tok_next.free_found;
    tok_out.free_idx   <= tok_next.free_idx;
    if (ins_here) begin
      key_high <= ins.key_high;
      key_low  <= ins.key_low;
      value    <= ins.data;
    end else if (match && tok_in.is_assign) begin
      value <= tok_in.data;
    end
  end

endmodule

// File: src/variable_symbol_table.sv
// ----------------------------------------------------------------------------
// variable_symbol_table: name-to-value table built as a chain of entry cells
// Each item walks the row one cell per cycle; an insert is broadcast after.
// ----------------------------------------------------------------------------
// An accepted item walks the TABLE_DEPTH cells, its outcome is registered in
// the decision step, and the result is registered in the output step after
// it; no new item is taken until the last one is through, and a result not
// yet taken holds the next item off.
// Reset (synchronous, active high) clears all valid bits and the entry count;
// stored keys and values are not cleared.
module variable_symbol_table (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         req_type,
  input  logic [vst_pkg::WORD_W-1:0]   name_high,
  input  logic [vst_pkg::WORD_W-1:0]   name_low,
  input  logic [vst_pkg::VALUE_W-1:0]  new_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic [vst_pkg::VALUE_W-1:0]  read_value
);
  import vst_pkg::*;

  state_t              state, state_next;
  tok_t                head;
  tok_t                chain [TABLE_DEPTH+1];
  ins_t                ins;
  logic [2*WORD_W-1:0] name_norm;
  logic [CNT_W-1:0]    entry_count;
  logic                in_fire;
  logic                tail_done;
  logic                hold_go;
  logic                chain_assign_q;

  // Result waiting for the output register.
  status_t             pend_status;
  logic [VALUE_W-1:0]  pend_value;
  logic                pend_ins;
  logic [IDX_W-1:0]    pend_idx;
  logic [WORD_W-1:0]   pend_key_high;
  logic [WORD_W-1:0]   pend_key_low;

  assign name_norm = normalize(name_high, name_low);
  assign in_fire   = in_valid && in_ready;
  assign tail_done = chain[TABLE_DEPTH].active;
  assign hold_go   = !out_valid || out_ready;

  always_comb begin
    head.active     = in_fire;
    head.is_assign  = req_type;
    head.key_high   = name_norm[2*WORD_W-1:WORD_W];
    head.key_low    = name_norm[WORD_W-1:0];
    head.data       = new_value;
    head.hit        = 1'b0;
    head.free_found = 1'b0;
    head.free_idx   = '0;
  end

  assign chain[0] = head;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    vst_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (IDX_W'(g)),
      .tok_in   (chain[g]),
      .ins      (ins),
      .tok_out  (chain[g+1])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_fire) state_next = S_SCAN;
      S_SCAN:  if (tail_done) state_next = S_HOLD;
      S_HOLD:  if (hold_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    ins.en       = 1'b0;
    ins.idx      = pend_idx;
    ins.key_high = pend_key_high;
    ins.key_low  = pend_key_low;
    ins.data     = pend_value;
    unique case (state)
      S_IDLE:  in_ready = 1'b1;
      S_SCAN:  ;
      S_HOLD:  ins.en = hold_go && pend_ins;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (ins.en) entry_count <= entry_count + CNT_W'(1);
      if (state == S_HOLD && hold_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Decide the outcome when the item leaves the last cell.
  always_ff @(posedge clk) begin
    if (state == S_SCAN && tail_done) begin
      pend_key_high <= chain[TABLE_DEPTH].key_high;
      pend_key_low  <= chain[TABLE_DEPTH].key_low;
      pend_idx      <= chain[TABLE_DEPTH].free_idx;
      pend_value    <= chain[TABLE_DEPTH].data;
      pend_ins      <= 1'b0;
      if (!chain[TABLE_DEPTH].is_assign) begin
        if (entry_count == '0) pend_status <= ST_EMPTY;
        else if (!chain[TABLE_DEPTH].hit) pend_status <= ST_NOT_FOUND;
        else pend_status <= ST_OK;
      end else if (chain[TABLE_DEPTH].hit) begin
        pend_status <= ST_OK;
      end else if (chain[TABLE_DEPTH].free_found) begin
        pend_status <= ST_OK;
        pend_ins    <= 1'b1;
      end else begin
        pend_status <= ST_FULL;
      end
    end
    if (state == S_HOLD && hold_go) begin
      status <= pend_status;
      // Only a successful lookup returns a value.
      read_value <= (pend_status == ST_OK && !pend_ins && !chain_assign_q)
                    ? pend_value : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN && tail_done) chain_assign_q <= chain[TABLE_DEPTH].is_assign;
  end

endmodule
